// ----- hdl/thdl_pkg.sv -----
// Shared types and constants for the token hash dictionary lookup unit.
package thdl_pkg;

  localparam int KEY_W  = 32;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 8;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;

  localparam logic [KEY_W-1:0] HASH_PRIME = 32'h0100_0193;

  // request kinds carried in tuser
  typedef enum logic [OP_W-1:0] {
    OP_BYTE      = 2'd0,
    OP_FIND_HASH = 2'd1,
    OP_FIND_OFFS = 2'd2,
    OP_APPEND    = 2'd3
  } op_t;

  // result status carried in tuser
  typedef enum logic [STAT_W-1:0] {
    STAT_FOUND = 2'd0,
    STAT_MISS  = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // control broadcast to every cell of the entry chain
  typedef struct packed {
    logic push;    // shift toward older cells, new entry enters cell 0
    logic rotate;  // shift toward cell 0, cell 0 wraps to the far end
  } cell_ctl_t;

endpackage

// ----- hdl/thdl_cell.sv -----
// One dictionary entry cell: holds a key and a code offset, takes a neighbor's entry.
module thdl_cell
  import thdl_pkg::*;
(
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [KEY_W-1:0] up_key,
  input  logic [KEY_W-1:0] up_offset,
  input  logic [KEY_W-1:0] dn_key,
  input  logic [KEY_W-1:0] dn_offset,
  output logic [KEY_W-1:0] key,
  output logic [KEY_W-1:0] offset
);

  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] offset_r;

  // take the newer neighbor on push, the older neighbor on rotate, else hold
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      key_r    <= up_key;
      offset_r <= up_offset;
    end else if (ctl.rotate) begin
      key_r    <= dn_key;
      offset_r <= dn_offset;
    end
  end

  assign key    = key_r;
  assign offset = offset_r;

endmodule

// ----- hdl/thdl_hash.sv -----
// Token hash accumulator: zero-based FNV-1a fold with zero-byte termination.
module thdl_hash
  import thdl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_en,
  input  logic [BYTE_W-1:0] byte_value,
  input  logic              last_byte,
  output logic [KEY_W-1:0]  hash_value
);

  logic [KEY_W-1:0] acc_r;
  logic [KEY_W-1:0] acc_nxt;
  logic             ended_r;
  logic             ended_nxt;
  logic [KEY_W-1:0] mixed;
  logic             zero_byte;

  assign zero_byte = (byte_value == '0);
  assign mixed     = acc_r ^ KEY_W'(byte_value);

  // fold the byte in unless the token already hit its terminator
  always_comb begin
    if (!ended_r && !zero_byte) begin
      hash_value = KEY_W'(mixed * HASH_PRIME);
    end else begin
      hash_value = acc_r;
    end
  end

  // clear after the last byte, otherwise keep the running hash
  always_comb begin
    acc_nxt   = acc_r;
    ended_nxt = ended_r;
    if (byte_en) begin
      if (last_byte) begin
        acc_nxt   = '0;
        ended_nxt = 1'b0;
      end else begin
        acc_nxt   = hash_value;
        ended_nxt = ended_r | zero_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      ended_r <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      ended_r <= ended_nxt;
    end
  end

endmodule

// ----- hdl/token_hash_dictionary_lookup_unit.sv -----
// Token hash dictionary lookup unit: request decode, entry chain and scan control.
//
// Requests arrive on the in_ stream (tuser = op, tlast = last byte of a token,
// tdata = byte value, search key, code offset). Token bytes are hashed at one
// per cycle while the unit is idle and give no result until the byte marked
// last. A lookup (last token byte, find by hash, find by offset) rotates the
// whole entry chain once past its head cell, comparing the newest entry first:
// the scan visits every cell, the result is held in a result register and then
// loaded into the output register, and only after that is the next request
// taken. An append pushes the new entry into the head of the chain at once; its
// result passes through the same result and output registers before the next
// request is taken. Non-final token bytes are taken every cycle while idle.
// in_tready is high whenever no lookup or result hand-off is in progress; a
// finished result waits in the out_ register while the next request is taken,
// and a stalled receiver only holds the unit once a second result is ready.
// Reset empties the dictionary (entry count zero) and clears the token hash;
// the entry cells themselves are not cleared and are only read once written.
module token_hash_dictionary_lookup_unit
  import thdl_pkg::*;
#(
  parameter int DICT_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // byte_value[7:0], search_key[39:8], code_offset[71:40]
  input  logic [1:0]  in_tuser,   // op[1:0]
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // dict_index[7:0], token_hash[39:8]
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int CNT_W  = $clog2(DICT_DEPTH + 1);
  localparam int STEP_W = $clog2(DICT_DEPTH);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DICT_DEPTH);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DICT_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // request fields
  op_t               req_op;
  logic [BYTE_W-1:0] req_byte;
  logic [KEY_W-1:0]  req_key;
  logic [KEY_W-1:0]  req_offset;
  logic              in_acc;

  assign req_op     = op_t'(in_tuser);
  assign req_byte   = in_tdata[7:0];
  assign req_key    = in_tdata[39:8];
  assign req_offset = in_tdata[71:40];
  assign in_acc     = in_tvalid && in_tready;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [KEY_W-1:0]  want_r, want_nxt;
  logic              by_offs_r, by_offs_nxt;
  logic              hit_r, hit_nxt;
  logic [CNT_W-1:0]  hit_idx_r, hit_idx_nxt;
  logic [KEY_W-1:0]  hit_key_r, hit_key_nxt;
  logic [STAT_W-1:0] res_stat_r, res_stat_nxt;
  logic [IDX_W-1:0]  res_idx_r, res_idx_nxt;
  logic [KEY_W-1:0]  res_hash_r, res_hash_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic [KEY_W-1:0]  out_hash_r, out_hash_nxt;

  logic              full;
  logic              out_free;
  logic [KEY_W-1:0]  hash_value;
  cell_ctl_t         ctl;
  logic [KEY_W-1:0]  key_q [DICT_DEPTH];
  logic [KEY_W-1:0]  offs_q [DICT_DEPTH];
  logic              match;
  logic              in_range;
  logic [CNT_W-1:0]  scan_idx;
  logic [CNT_W+IDX_W-1:0] cnt_wide;
  logic [CNT_W+IDX_W-1:0] hit_wide;

  assign full     = (count_r == FULL_CNT);
  assign out_free = !out_valid_r || out_tready;

  // token hash
  thdl_hash u_hash (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_en    (in_acc && (req_op == OP_BYTE)),
    .byte_value (req_byte),
    .last_byte  (in_tlast),
    .hash_value (hash_value)
  );

  // entry chain: cell 0 holds the newest entry
  assign ctl.push   = in_acc && (req_op == OP_APPEND) && !full;
  assign ctl.rotate = (state_r == ST_SCAN);

  for (genvar i = 0; i < DICT_DEPTH; i++) begin : g_cell
    localparam int UP = (i == 0) ? 0 : i - 1;
    localparam int DN = (i == DICT_DEPTH - 1) ? 0 : i + 1;
    thdl_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .up_key    ((i == 0) ? req_key : key_q[UP]),
      .up_offset ((i == 0) ? req_offset : offs_q[UP]),
      .dn_key    (key_q[DN]),
      .dn_offset (offs_q[DN]),
      .key       (key_q[i]),
      .offset    (offs_q[i])
    );
  end

  // head-cell compare; step k sees entry count-1-k
  assign match    = by_offs_r ? (offs_q[0] == want_r) : (key_q[0] == want_r);
  assign in_range = (CNT_W'(step_r) < count_r);
  assign scan_idx = count_r - CNT_W'(1) - CNT_W'(step_r);
  assign cnt_wide = {{IDX_W{1'b0}}, count_r};
  assign hit_wide = {{IDX_W{1'b0}}, hit_idx_nxt};

  // request decode, scan sequencing and result hand-off
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    count_nxt     = count_r;
    want_nxt      = want_r;
    by_offs_nxt   = by_offs_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_key_nxt   = hit_key_r;
    res_stat_nxt  = res_stat_r;
    res_idx_nxt   = res_idx_r;
    res_hash_nxt  = res_hash_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_stat_nxt  = out_stat_r;
    out_idx_nxt   = out_idx_r;
    out_hash_nxt  = out_hash_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          step_nxt = '0;
          hit_nxt  = 1'b0;
          unique case (req_op)
            OP_BYTE: begin
              if (in_tlast) begin
                want_nxt    = hash_value;
                by_offs_nxt = 1'b0;
                state_nxt   = ST_SCAN;
              end
            end
            OP_FIND_HASH: begin
              want_nxt    = req_key;
              by_offs_nxt = 1'b0;
              state_nxt   = ST_SCAN;
            end
            OP_FIND_OFFS: begin
              want_nxt    = req_offset;
              by_offs_nxt = 1'b1;
              state_nxt   = ST_SCAN;
            end
            OP_APPEND: begin
              res_hash_nxt = req_key;
              if (full) begin
                res_stat_nxt = STAT_FULL;
                res_idx_nxt  = '0;
              end else begin
                res_stat_nxt = STAT_FOUND;
                res_idx_nxt  = cnt_wide[IDX_W-1:0];
                count_nxt    = count_r + CNT_W'(1);
              end
              state_nxt = ST_EMIT;
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        // record the first in-range match
        if (!hit_r && in_range && match) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = scan_idx;
          hit_key_nxt = key_q[0];
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == LAST_STEP) begin
          res_stat_nxt = hit_nxt ? STAT_FOUND : STAT_MISS;
          res_idx_nxt  = hit_nxt ? hit_wide[IDX_W-1:0] : '0;
          if (by_offs_r) begin
            res_hash_nxt = hit_nxt ? hit_key_nxt : '0;
          end else begin
            res_hash_nxt = want_r;
          end
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        // move the result into the output register once it is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = res_stat_r;
          out_idx_nxt   = res_idx_r;
          out_hash_nxt  = res_hash_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      hit_r       <= hit_nxt;
      step_r      <= step_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    want_r     <= want_nxt;
    by_offs_r  <= by_offs_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_key_r  <= hit_key_nxt;
    res_stat_r <= res_stat_nxt;
    res_idx_r  <= res_idx_nxt;
    res_hash_r <= res_hash_nxt;
    out_stat_r <= out_stat_nxt;
    out_idx_r  <= out_idx_nxt;
    out_hash_r <= out_hash_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_hash_r, out_idx_r};
  assign out_tuser  = out_stat_r;

  // entry count never passes the chain length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above dictionary depth");

  // no request is taken while the chain rotates
  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !in_tready)
    else $error("request accepted during scan");

  // a scan ends after exactly one full rotation
  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && step_r == LAST_STEP) |=> (state_r == ST_EMIT))
    else $error("scan did not finish after full rotation");

  // an append into a non-full chain grows the count by one
  a_append_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("append did not advance entry count");

endmodule

// ----- dv/tb_token_hash_dictionary_lookup_unit.sv -----
// Testbench for the token hash dictionary lookup unit: predicts and checks every result.
`timescale 1ns / 100ps

module tb_token_hash_dictionary_lookup_unit;
  import thdl_pkg::*;

  localparam int DICT_DEPTH   = 256;
  localparam int RANDOM_ITEMS = 80;
  localparam int HOLD_AFTER   = 60;      // results taken before the long receiver hold
  localparam int HOLD_CYCLES  = 3000;
  localparam int SETTLE       = DICT_DEPTH + 16;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    op_t         op;
    logic [7:0]  byte_value;
    logic        last;
    logic [31:0] key;
    logic [31:0] offs;
    logic        drain;  // hold this request until every result is back
  } request_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  idx;
    logic [31:0] hash;
  } lookup_result_t;

  typedef struct packed {
    logic [63:0] chars;  // first character in the low byte
    logic [3:0]  len;
  } word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  // pending stimulus and results still owed by the block
  request_t       pending_requests[$];
  lookup_result_t lookup_results_due[$];

  // predicted dictionary and token state
  logic [31:0] dict_key [DICT_DEPTH];
  logic [31:0] dict_offs [DICT_DEPTH];
  int          dict_count = 0;
  logic [31:0] tok_hash = '0;
  logic        tok_ended = 1'b0;

  // generator bookkeeping
  logic [31:0] gen_keys[$];
  logic [31:0] gen_offs[$];
  word_t       known_words[$];
  int          appends_issued = 0;
  bit          mark_drain = 1'b0;

  // handshake flags and counters
  logic req_taken = 1'b0;
  logic rx_taken = 1'b0;
  int   results_taken = 0;
  int   mismatches = 0;
  int   cycles = 0;

  // driver and receiver state
  request_t tx_next;
  bit       tx_have = 1'b0;
  bit       tx_burst = 1'b0;
  int       tx_gap = 0;
  bit       rx_burst = 1'b0;
  int       rx_wait = 0;

  token_hash_dictionary_lookup_unit #(.DICT_DEPTH(DICT_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // fold one character into the running hash
  function automatic logic [31:0] fnv_fold(input logic [31:0] acc, input logic [7:0] ch);
    return (acc ^ {24'd0, ch}) * HASH_PRIME;
  endfunction

  function automatic logic [31:0] word_hash(input word_t w);
    logic [31:0] acc;
    acc = '0;
    for (int i = 0; i < w.len; i++) acc = fnv_fold(acc, w.chars[8*i +: 8]);
    return acc;
  endfunction

  // newest matching entry, or -1 when none
  function automatic int newest_match(input bit by_offs, input logic [31:0] want);
    for (int i = dict_count - 1; i >= 0; i--) begin
      if ((by_offs ? dict_offs[i] : dict_key[i]) == want) return i;
    end
    return -1;
  endfunction

  // advance the predicted dictionary by one request, queue the result it owes
  task automatic predict_request(input op_t op, input logic [7:0] ch, input logic last,
                                 input logic [31:0] key, input logic [31:0] offs);
    lookup_result_t res;
    int hit;
    hit = -1;
    res.hash = key;
    case (op)
      OP_BYTE: begin
        if (!tok_ended) begin
          if (ch == 8'h00) tok_ended = 1'b1;
          else tok_hash = fnv_fold(tok_hash, ch);
        end
        if (last) begin
          res.hash = tok_hash;
          hit = newest_match(1'b0, tok_hash);
          tok_hash = '0;
          tok_ended = 1'b0;
        end
      end
      OP_FIND_HASH: hit = newest_match(1'b0, key);
      OP_FIND_OFFS: begin
        hit = newest_match(1'b1, offs);
        res.hash = (hit >= 0) ? dict_key[hit] : '0;
      end
      default: begin
        if (dict_count < DICT_DEPTH) begin
          dict_key[dict_count] = key;
          dict_offs[dict_count] = offs;
          hit = dict_count;
          dict_count++;
        end
      end
    endcase
    if (op == OP_BYTE && !last) return;
    if (hit >= 0) begin
      res.status = STAT_FOUND;
      res.idx = hit[7:0];
    end else begin
      res.status = (op == OP_APPEND) ? STAT_FULL : STAT_MISS;
      res.idx = '0;
    end
    lookup_results_due.push_back(res);
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("result %0d: %s expected %h, got %h", results_taken, what, want, got);
  endtask

  task automatic queue_request(input op_t op, input logic [7:0] ch, input logic last,
                               input logic [31:0] key, input logic [31:0] offs);
    request_t r;
    r.op = op;
    r.byte_value = ch;
    r.last = last;
    r.key = key;
    r.offs = offs;
    r.drain = mark_drain;
    mark_drain = 1'b0;
    pending_requests.push_back(r);
  endtask

  // append with random filler in the unused fields; track what gets stored
  task automatic queue_append(input logic [31:0] key, input logic [31:0] offs);
    queue_request(OP_APPEND, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  key, offs);
    if (appends_issued < DICT_DEPTH) begin
      gen_keys.push_back(key);
      gen_offs.push_back(offs);
    end
    appends_issued++;
  endtask

  // send a word as a token; with a zero tail the hash stops at the word
  task automatic queue_token(input word_t w, input bit zero_tail);
    int tail;
    tail = zero_tail ? $urandom_range(0, 3) : 0;
    for (int i = 0; i < w.len; i++)
      queue_request(OP_BYTE, w.chars[8*i +: 8], !zero_tail && (i == w.len - 1),
                    $urandom, $urandom);
    if (zero_tail) begin
      queue_request(OP_BYTE, 8'h00, tail == 0, $urandom, $urandom);
      for (int i = 1; i <= tail; i++)
        queue_request(OP_BYTE, 8'($urandom_range(0, 255)), i == tail, $urandom, $urandom);
    end
  endtask

  function automatic word_t random_word();
    word_t w;
    w.len = 4'($urandom_range(1, 8));
    for (int i = 0; i < 8; i++) w.chars[8*i +: 8] = 8'($urandom_range(1, 255));
    return w;
  endfunction

  // sender: one request per draw, random gap ahead of each
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || req_taken)) begin
      if (!tx_have && pending_requests.size() != 0) begin
        tx_next = pending_requests.pop_front();
        tx_have = 1'b1;
        if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
        tx_gap = tx_burst ? 0 : $urandom_range(0, 16);
      end
      if (tx_have && tx_gap == 0 && !(tx_next.drain && lookup_results_due.size() != 0)) begin
        in_tdata  <= {tx_next.offs, tx_next.key, tx_next.byte_value};
        in_tuser  <= tx_next.op;
        in_tlast  <= tx_next.last;
        in_tvalid <= 1'b1;
        tx_have = 1'b0;
      end else begin
        if (tx_have && tx_gap > 0) tx_gap = tx_gap - 1;
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stall after each result, one long hold to back up the input
  always @(negedge clk) begin
    if (rst_n) begin
      if (rx_taken) begin
        if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
        rx_wait = rx_burst ? 0 : $urandom_range(0, 16);
        if (results_taken == HOLD_AFTER) rx_wait = HOLD_CYCLES;
      end
      if (rx_wait > 0) begin
        rx_wait = rx_wait - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // predict on each accepted request, check each accepted result
  always @(posedge clk) begin : monitor
    lookup_result_t due;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (rst_n) begin
      req_taken <= in_tvalid && in_tready;
      rx_taken  <= out_tvalid && out_tready;
      if (in_tvalid && in_tready)
        predict_request(op_t'(in_tuser), in_tdata[7:0], in_tlast, in_tdata[39:8],
                        in_tdata[71:40]);
      if (out_tvalid && out_tready) begin
        results_taken++;
        if (lookup_results_due.size() == 0) begin
          flag_mismatch("unexpected result, hash", '0, out_tdata[39:8]);
        end else begin
          due = lookup_results_due.pop_front();
          if (out_tuser !== due.status)
            flag_mismatch("status", 32'(due.status), 32'(out_tuser));
          if (out_tdata[7:0] !== due.idx)
            flag_mismatch("entry index", 32'(due.idx), 32'(out_tdata[7:0]));
          if (out_tdata[39:8] !== due.hash) flag_mismatch("token hash", due.hash, out_tdata[39:8]);
        end
      end
    end
  end

  initial begin : stimulus
    word_t       w;
    logic [31:0] key;
    logic [31:0] offs;
    int          goal;
    int          pick;

    // empty dictionary: empty token and both finds miss
    queue_request(OP_BYTE, 8'h00, 1'b1, 32'h0, 32'h0);
    queue_request(OP_FIND_HASH, 8'hFF, 1'b0, 32'h0, 32'hFFFF_FFFF);
    queue_request(OP_FIND_OFFS, 8'h00, 1'b0, 32'hFFFF_FFFF, 32'h0);
    queue_append(32'h0, 32'hFFFF_FFFF);
    queue_request(OP_BYTE, 8'h00, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // bytes after a zero are ignored, including the last one
    w.chars = 64'h01FF;
    w.len = 4'd2;
    queue_request(OP_BYTE, 8'hFF, 1'b0, 32'h0, 32'h0);
    queue_request(OP_BYTE, 8'h01, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(OP_BYTE, 8'h00, 1'b0, 32'h0, 32'h0);
    queue_request(OP_BYTE, 8'h7F, 1'b0, 32'h0, 32'h0);
    queue_request(OP_BYTE, 8'h80, 1'b1, 32'h0, 32'h0);
    queue_append(word_hash(w), 32'h0);
    known_words.push_back(w);
    queue_token(w, 1'b0);
    queue_request(OP_FIND_OFFS, 8'h00, 1'b0, 32'h0, 32'hFFFF_FFFF);
    queue_request(OP_FIND_OFFS, 8'hFF, 1'b1, 32'hFFFF_FFFF, 32'h0);
    // duplicate key: the newest entry wins
    queue_append(32'h0, 32'h0000_1234);
    queue_request(OP_FIND_HASH, 8'h00, 1'b0, 32'h0, 32'h0);
    queue_request(OP_FIND_HASH, 8'h00, 1'b1, 32'hFFFF_FFFF, 32'h0);
    // other ops in the middle of a token leave it alone
    queue_request(OP_BYTE, 8'h41, 1'b0, 32'h0, 32'h0);
    queue_request(OP_FIND_HASH, 8'hFF, 1'b1, word_hash(w), 32'h0);
    queue_append(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(OP_BYTE, 8'h42, 1'b1, 32'h0, 32'h0);
    queue_request(OP_FIND_OFFS, 8'h00, 1'b0, 32'h0, 32'hFFFF_FFFF);

    // random mix, mostly well-formed tokens against stored words
    goal = pending_requests.size() + RANDOM_ITEMS;
    mark_drain = 1'b1;
    while (pending_requests.size() < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        if (known_words.size() != 0 && $urandom_range(0, 3) != 0)
          w = known_words[$urandom_range(0, known_words.size() - 1)];
        else
          w = random_word();
        queue_token(w, $urandom_range(0, 3) == 0);
      end else if (pick < 60 || (pick >= 92 && $urandom_range(0, 3) == 0)) begin
        w = random_word();
        case ($urandom_range(0, 4))
          0: key = $urandom;
          1: key = (gen_keys.size() != 0) ? gen_keys[$urandom_range(0, gen_keys.size() - 1)]
                                          : $urandom;
          default: begin
            key = word_hash(w);
            if (appends_issued < DICT_DEPTH) known_words.push_back(w);
          end
        endcase
        if (gen_offs.size() != 0 && $urandom_range(0, 3) == 0)
          offs = gen_offs[$urandom_range(0, gen_offs.size() - 1)];
        else
          offs = $urandom;
        queue_append(key, offs);
      end else if (pick < 75) begin
        key = (gen_keys.size() != 0 && $urandom_range(0, 1) != 0)
              ? gen_keys[$urandom_range(0, gen_keys.size() - 1)] : $urandom;
        queue_request(OP_FIND_HASH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      key, $urandom);
      end else if (pick < 90) begin
        offs = (gen_offs.size() != 0 && $urandom_range(0, 1) != 0)
               ? gen_offs[$urandom_range(0, gen_offs.size() - 1)] : $urandom;
        queue_request(OP_FIND_OFFS, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      $urandom, offs);
      end else begin
        // noise: any op but append, any fields, may split a token
        queue_request(op_t'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), $urandom, $urandom);
      end
    end

    // fill the dictionary, then push past full
    mark_drain = 1'b1;
    while (appends_issued < DICT_DEPTH + 3) begin
      if (appends_issued % 16 == 0 && known_words.size() != 0)
        queue_token(known_words[$urandom_range(0, known_words.size() - 1)], 1'b0);
      w = random_word();
      if (appends_issued < DICT_DEPTH) known_words.push_back(w);
      queue_append(word_hash(w), $urandom);
    end
    // full scans: oldest key, newest offset, a stored word, a miss
    queue_request(OP_FIND_HASH, 8'h00, 1'b0, gen_keys[0], 32'h0);
    queue_request(OP_FIND_OFFS, 8'h00, 1'b0, 32'h0, gen_offs[DICT_DEPTH - 1]);
    queue_token(known_words[0], 1'b1);
    queue_request(OP_FIND_HASH, 8'h00, 1'b0, $urandom, 32'h0);

    // reset, then wait for the traffic to drain
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (pending_requests.size() != 0 || tx_have || in_tvalid ||
           lookup_results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && lookup_results_due.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
